[hw/rtl/hec_pkg.sv]
// hec_pkg: shared types and constants for the nand hamming ecc check core
// used by hec_accum, hec_classify, hec_check and nand_hamming_ecc_check_core
package hec_pkg;

    localparam int unsigned ECC_OUT_W  = 24;
    localparam int unsigned BYTE_OUT_W = 9;

    // column parity masks, in ecc bit order 5 down to 0
    localparam logic [7:0] MASK_0F = 8'h0f;
    localparam logic [7:0] MASK_F0 = 8'hf0;
    localparam logic [7:0] MASK_33 = 8'h33;
    localparam logic [7:0] MASK_CC = 8'hcc;
    localparam logic [7:0] MASK_55 = 8'h55;
    localparam logic [7:0] MASK_AA = 8'haa;

    typedef enum logic [1:0] {
        ST_CLEAN    = 2'd0,
        ST_ECC_ERR  = 2'd1,
        ST_DATA_FIX = 2'd2,
        ST_UNCORR   = 2'd3
    } t_status;

    typedef struct packed {
        logic [ECC_OUT_W-1:0]  ecc_code;
        logic [ECC_OUT_W-1:0]  syndrome;
        t_status               status;
        logic [BYTE_OUT_W-1:0] error_byte;
        logic [2:0]            error_bit;
        logic                  fix_in_range;
    } t_result;

endpackage

[hw/rtl/nand_hamming_ecc_check_core.sv]
// Streaming hamming ecc generator and checker for nand chunks of up to
// 2**LOG2_CHUNK_BYTES bytes. It takes one data byte per cycle unless the
// input stalls, each byte being one xor update of the column and line
// accumulators. A byte is held in the input register, then folded into the
// accumulators; on the byte marked last the inverted ecc, the syndrome and
// the error class land in the result register as that byte leaves the input
// register. Bytes without last give no result. The input side keeps
// taking bytes while a result waits, and stalls only when a last byte meets
// a result register that is still full. Reported error positions are never
// corrected here; the caller flips the bit.
// depends on hec_pkg, hec_accum, hec_classify
module nand_hamming_ecc_check_core #(
    parameter int unsigned LOG2_CHUNK_BYTES = 9
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_kind,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last,
    input  logic [23:0] i_stored_ecc,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [23:0] o_ecc_code,
    output logic [23:0] o_syndrome,
    output logic [1:0]  o_status,
    output logic [8:0]  o_error_byte,
    output logic [2:0]  o_error_bit,
    output logic        o_fix_in_range
);
    localparam int unsigned L       = LOG2_CHUNK_BYTES;
    localparam int unsigned EccBits = 2 * L + 6;

    logic        r_in_vld;
    logic        r_in_kind;
    logic [7:0]  r_in_data;
    logic        r_in_last;
    logic [23:0] r_in_stored;

    logic             r_out_vld;
    hec_pkg::t_result r_out;
    hec_pkg::t_result n_out;

    logic               out_free;
    logic               in_advance;
    logic               in_take;
    logic [EccBits-1:0] ecc;
    logic [L:0]         len;

    assign out_free   = ~r_out_vld | i_out_ready;
    assign in_advance = r_in_vld & (~r_in_last | out_free);
    assign o_in_ready = ~r_in_vld | in_advance;
    assign in_take    = i_in_valid & o_in_ready;

    hec_accum #(
        .LOG2_CHUNK_BYTES(LOG2_CHUNK_BYTES)
    ) u_accum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (in_advance),
        .i_data_byte(r_in_data),
        .i_last     (r_in_last),
        .o_ecc      (ecc),
        .o_len      (len)
    );

    hec_classify #(
        .LOG2_CHUNK_BYTES(LOG2_CHUNK_BYTES)
    ) u_classify (
        .i_kind      (r_in_kind),
        .i_ecc       (ecc),
        .i_stored_ecc(r_in_stored),
        .i_len       (len),
        .o_result    (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_kind   <= i_kind;
            r_in_data   <= i_data_byte;
            r_in_last   <= i_last;
            r_in_stored <= i_stored_ecc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (in_advance && r_in_last) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_advance && r_in_last) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_ecc_code     = r_out.ecc_code;
    assign o_syndrome     = r_out.syndrome;
    assign o_status       = r_out.status;
    assign o_error_byte   = r_out.error_byte;
    assign o_error_bit    = r_out.error_bit;
    assign o_fix_in_range = r_out.fix_in_range;

endmodule

[hw/rtl/hec_accum.sv]
// hec_accum: running column and line parity of a chunk, one byte a step
// forms the inverted ecc of the chunk up to and including the current byte
// depends on hec_pkg
module hec_accum #(
    parameter int unsigned LOG2_CHUNK_BYTES = 9
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_step,
    input  logic [7:0]                      i_data_byte,
    input  logic                            i_last,
    output logic [2*LOG2_CHUNK_BYTES+5:0]   o_ecc,
    output logic [LOG2_CHUNK_BYTES:0]       o_len
);
    localparam int unsigned L       = LOG2_CHUNK_BYTES;
    localparam int unsigned EccBits = 2 * L + 6;
    localparam logic [L:0]  ChunkLen = {1'b1, {L{1'b0}}};

    logic [7:0]   r_col,  n_col;
    logic [L-1:0] r_line, n_line;
    logic [L-1:0] r_bar,  n_bar;
    logic [L-1:0] r_idx,  n_idx;
    logic [L:0]   r_cnt,  n_cnt;
    logic         odd;
    logic [EccBits-1:0] raw;

    always_comb begin
        odd    = ^i_data_byte;
        n_col  = r_col ^ i_data_byte;
        n_line = odd ? (r_line ^ r_idx) : r_line;
        n_bar  = odd ? (r_bar ^ ~r_idx) : r_bar;
        n_idx  = r_idx + 1'b1;
        // count saturates at the chunk size so an overlong chunk is all in range
        n_cnt  = (r_cnt < ChunkLen) ? r_cnt + 1'b1 : r_cnt;

        for (int k = 0; k < int'(L); k++) begin
            raw[2*k+6] = n_line[k];
            raw[2*k+7] = n_bar[k];
        end
        raw[5] = ^(n_col & hec_pkg::MASK_0F);
        raw[4] = ^(n_col & hec_pkg::MASK_F0);
        raw[3] = ^(n_col & hec_pkg::MASK_33);
        raw[2] = ^(n_col & hec_pkg::MASK_CC);
        raw[1] = ^(n_col & hec_pkg::MASK_55);
        raw[0] = ^(n_col & hec_pkg::MASK_AA);

        o_ecc = ~raw;
        o_len = n_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_line <= '0;
            r_bar  <= '0;
            r_idx  <= '0;
            r_cnt  <= '0;
        end else if (i_step) begin
            if (i_last) begin
                r_col  <= '0;
                r_line <= '0;
                r_bar  <= '0;
                r_idx  <= '0;
                r_cnt  <= '0;
            end else begin
                r_col  <= n_col;
                r_line <= n_line;
                r_bar  <= n_bar;
                r_idx  <= n_idx;
                r_cnt  <= n_cnt;
            end
        end
    end

endmodule

[hw/rtl/hec_classify.sv]
// hec_classify: syndrome against the stored ecc and error classification
// depends on hec_pkg (t_result, t_status)
module hec_classify #(
    parameter int unsigned LOG2_CHUNK_BYTES = 9
) (
    input  logic                            i_kind,
    input  logic [2*LOG2_CHUNK_BYTES+5:0]   i_ecc,
    input  logic [hec_pkg::ECC_OUT_W-1:0]   i_stored_ecc,
    input  logic [LOG2_CHUNK_BYTES:0]       i_len,
    output hec_pkg::t_result                o_result
);
    localparam int unsigned L       = LOG2_CHUNK_BYTES;
    localparam int unsigned EccBits = 2 * L + 6;
    localparam int unsigned Pairs   = L + 3;

    logic [EccBits-1:0] stored_ext;
    logic [EccBits-1:0] syn;
    logic [hec_pkg::ECC_OUT_W-1:0] ecc_out;
    logic [hec_pkg::ECC_OUT_W-1:0] syn_out;
    logic [Pairs-1:0] pos;
    logic [L-1:0]     ebyte;
    logic [hec_pkg::BYTE_OUT_W-1:0] ebyte_out;
    logic             bad;
    logic             single;

    if (EccBits > hec_pkg::ECC_OUT_W) begin : g_wide
        assign stored_ext = {{(EccBits - hec_pkg::ECC_OUT_W){1'b0}}, i_stored_ecc};
        assign ecc_out    = i_ecc[hec_pkg::ECC_OUT_W-1:0];
        assign syn_out    = syn[hec_pkg::ECC_OUT_W-1:0];
    end else if (EccBits == hec_pkg::ECC_OUT_W) begin : g_exact
        assign stored_ext = i_stored_ecc;
        assign ecc_out    = i_ecc;
        assign syn_out    = syn;
    end else begin : g_narrow
        assign stored_ext = i_stored_ecc[EccBits-1:0];
        assign ecc_out    = {{(hec_pkg::ECC_OUT_W - EccBits){1'b0}}, i_ecc};
        assign syn_out    = {{(hec_pkg::ECC_OUT_W - EccBits){1'b0}}, syn};
    end

    assign ebyte = pos[Pairs-1:3];

    if (L >= hec_pkg::BYTE_OUT_W) begin : g_byte_trunc
        assign ebyte_out = ebyte[hec_pkg::BYTE_OUT_W-1:0];
    end else begin : g_byte_ext
        assign ebyte_out = {{(hec_pkg::BYTE_OUT_W - L){1'b0}}, ebyte};
    end

    always_comb begin
        syn    = i_kind ? (i_ecc ^ stored_ext) : '0;
        single = ((syn & (syn - 1'b1)) == '0);

        // each bit pair must read 01 or 10 for a correctable data bit
        bad = 1'b0;
        for (int i = 0; i < int'(Pairs); i++) begin
            pos[i] = ~syn[2*i+1] & syn[2*i];
            bad    = bad | ~(syn[2*i+1] ^ syn[2*i]);
        end

        o_result              = '0;
        o_result.ecc_code     = ecc_out;
        o_result.syndrome     = syn_out;
        if (syn == '0) begin
            o_result.status = hec_pkg::ST_CLEAN;
        end else if (single) begin
            o_result.status = hec_pkg::ST_ECC_ERR;
        end else if (bad) begin
            o_result.status = hec_pkg::ST_UNCORR;
        end else begin
            o_result.status       = hec_pkg::ST_DATA_FIX;
            o_result.error_byte   = ebyte_out;
            o_result.error_bit    = pos[2:0];
            o_result.fix_in_range = ({1'b0, ebyte} < i_len);
        end
    end

endmodule

[hw/rtl/hec_check.sv]
// hec_check: port-level checks on the ecc check core result beats
// depends on hec_pkg; bound to nand_hamming_ecc_check_core below
module hec_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [23:0] o_ecc_code,
    input logic [23:0] o_syndrome,
    input logic [1:0]  o_status,
    input logic [8:0]  o_error_byte,
    input logic [2:0]  o_error_bit,
    input logic        o_fix_in_range
);

    // position fields are only meaningful for a correctable data bit
    a_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != hec_pkg::ST_DATA_FIX) |->
            (o_error_byte == 9'd0 && o_error_bit == 3'd0 && !o_fix_in_range))
        else $error("position fields set without a correctable data bit");

    a_clean_syn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == hec_pkg::ST_CLEAN) |-> (o_syndrome == 24'd0))
        else $error("clean status with nonzero syndrome");

    a_ecc_err_syn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == hec_pkg::ST_ECC_ERR) |-> $onehot0(o_syndrome))
        else $error("ecc byte error with more than one syndrome bit");

    a_fix_syn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == hec_pkg::ST_DATA_FIX) |->
            ($countones(o_syndrome) > 1))
        else $error("correctable data bit with sparse syndrome");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_ecc_code) && $stable(o_status)))
        else $error("result beat changed while stalled");

endmodule

bind nand_hamming_ecc_check_core hec_check u_hec_check (.*);

[sim/nand_hamming_ecc_check_core_tb.sv]
// testbench for nand_hamming_ecc_check_core: directed table, then random chunks
// checked against an in-bench ecc/syndrome predictor; needs hec_pkg and the core rtl
`timescale 1ns / 100ps

module nand_hamming_ecc_check_core_tb;

    localparam int LOG2_CHUNK = 9;
    localparam int CHUNK_LEN  = 1 << LOG2_CHUNK;
    localparam int RAND_BEATS = 680;
    localparam int IDLE_LIMIT = 3000;
    localparam int HOLD_OFF   = 400;
    localparam int DRAIN_WAIT = 8;

    typedef struct packed {
        logic [7:0] col;
        logic [8:0] line;
        logic [8:0] line_inv;
        logic [8:0] idx;
        logic [9:0] cnt;
    } t_acc;

    typedef enum logic {STORED_LIT, STORED_REF} t_stored_src;

    typedef struct {
        logic             kind;
        logic [7:0]       data;
        logic             last;
        t_stored_src      src;
        logic [23:0]      stored;
        logic             typed;
        hec_pkg::t_result want;
    } t_row;

    typedef struct {
        logic             kind;
        logic [7:0]       data;
        logic             last;
        logic [23:0]      stored;
        logic             typed;
        hec_pkg::t_result want;
    } t_beat;

    localparam hec_pkg::t_result NO_WANT = '0;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_kind = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_last = 1'b0;
    logic [23:0] i_stored_ecc = 24'h000000;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [23:0] o_ecc_code;
    logic [23:0] o_syndrome;
    logic [1:0]  o_status;
    logic [8:0]  o_error_byte;
    logic [2:0]  o_error_bit;
    logic        o_fix_in_range;

    t_row             dir_tab [21];
    t_beat            beat_q [$];
    hec_pkg::t_result want_q [$];
    t_acc             pred_acc = '0;
    int               n_taken = 0;
    int               n_results = 0;
    int               n_errors = 0;
    int               idle_cycles = 0;

    nand_hamming_ecc_check_core #(
        .LOG2_CHUNK_BYTES(LOG2_CHUNK)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_kind         (i_kind),
        .i_data_byte    (i_data_byte),
        .i_last         (i_last),
        .i_stored_ecc   (i_stored_ecc),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_ecc_code     (o_ecc_code),
        .o_syndrome     (o_syndrome),
        .o_status       (o_status),
        .o_error_byte   (o_error_byte),
        .o_error_bit    (o_error_bit),
        .o_fix_in_range (o_fix_in_range)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // column parity always; line parities only for odd-parity bytes
    function automatic t_acc acc_fold(t_acc a, logic [7:0] d);
        a.col = a.col ^ d;
        if (^d) begin
            a.line     = a.line ^ a.idx;
            a.line_inv = a.line_inv ^ ~a.idx;
        end
        if (a.cnt < CHUNK_LEN)
            a.cnt = a.cnt + 10'd1;
        a.idx = a.idx + 9'd1;
        return a;
    endfunction

    function automatic logic [23:0] acc_ecc(t_acc a);
        logic [23:0] e;
        e = '0;
        for (int k = 0; k < LOG2_CHUNK; k++) begin
            e[2*k+6] = a.line[k];
            e[2*k+7] = a.line_inv[k];
        end
        e[5] = ^(a.col & hec_pkg::MASK_0F);
        e[4] = ^(a.col & hec_pkg::MASK_F0);
        e[3] = ^(a.col & hec_pkg::MASK_33);
        e[2] = ^(a.col & hec_pkg::MASK_CC);
        e[1] = ^(a.col & hec_pkg::MASK_55);
        e[0] = ^(a.col & hec_pkg::MASK_AA);
        return ~e;
    endfunction

    function automatic hec_pkg::t_result ecc_verdict(logic kind, logic [23:0] ecc,
                                                     logic [23:0] stored, logic [9:0] len);
        hec_pkg::t_result r;
        logic [23:0]      syn;
        logic [11:0]      pos;
        logic             broken;
        r = '0;
        r.ecc_code = ecc;
        r.status = hec_pkg::ST_CLEAN;
        if (kind) begin
            syn = ecc ^ stored;
            r.syndrome = syn;
            if (syn == '0) begin
                r.status = hec_pkg::ST_CLEAN;
            end else if ((syn & (syn - 24'd1)) == '0) begin
                r.status = hec_pkg::ST_ECC_ERR;
            end else begin
                pos = '0;
                broken = 1'b0;
                // each pair must read 01 (position bit set) or 10 (clear)
                for (int i = 0; i < 12; i++) begin
                    case (syn[2*i +: 2])
                        2'b01: pos[i] = 1'b1;
                        2'b10: pos[i] = 1'b0;
                        default: broken = 1'b1;
                    endcase
                end
                if (broken) begin
                    r.status = hec_pkg::ST_UNCORR;
                end else begin
                    r.status = hec_pkg::ST_DATA_FIX;
                    r.error_byte = pos[11:3];
                    r.error_bit = pos[2:0];
                    r.fix_in_range = ({1'b0, pos[11:3]} < len);
                end
            end
        end
        return r;
    endfunction

    task automatic add_chunk(int len);
        t_acc        a;
        t_beat       b;
        logic [23:0] e;
        logic [23:0] syn;
        logic [11:0] pos;
        int          sel;
        int          p;
        int          span;
        a = '0;
        for (int j = 0; j < len; j++) begin
            sel = $urandom_range(0, 9);
            b.data = (sel == 0) ? 8'h00 : (sel == 1) ? 8'hff : 8'($urandom_range(0, 255));
            b.kind = 1'($urandom_range(0, 1));
            b.stored = 24'($urandom);
            b.last = (j == len - 1);
            b.typed = 1'b0;
            b.want = NO_WANT;
            a = acc_fold(a, b.data);
            if (b.last) begin
                e = acc_ecc(a);
                b.kind = ($urandom_range(0, 9) >= 3);
                if (b.kind) begin
                    sel = $urandom_range(0, 9);
                    syn = 24'($urandom);
                    if (sel <= 1) begin
                        syn = '0;
                    end else if (sel <= 3) begin
                        syn = 24'h1 << $urandom_range(0, 23);
                    end else if (sel <= 6 || sel == 9) begin
                        span = (a.cnt < CHUNK_LEN) ? int'(a.cnt) : CHUNK_LEN;
                        if ($urandom_range(0, 3) == 0)
                            pos = 12'($urandom);
                        else
                            pos = {9'($urandom_range(0, span - 1)), 3'($urandom_range(0, 7))};
                        for (int i = 0; i < 12; i++)
                            syn[2*i +: 2] = pos[i] ? 2'b01 : 2'b10;
                        // spoil one pair to force the uncorrectable path
                        if (sel == 9) begin
                            p = $urandom_range(0, 11);
                            syn[2*p +: 2] = $urandom_range(0, 1) ? 2'b00 : 2'b11;
                        end
                    end
                    b.stored = e ^ syn;
                end
            end
            beat_q.push_back(b);
        end
    endtask

    // predictor follows every accepted beat
    always @(posedge i_clk) begin : in_mon
        t_beat            b;
        hec_pkg::t_result r;
        logic [23:0]      e;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            if (n_taken < beat_q.size()) begin
                b = beat_q[n_taken];
                pred_acc = acc_fold(pred_acc, b.data);
                if (b.last) begin
                    e = acc_ecc(pred_acc);
                    r = ecc_verdict(b.kind, e, b.stored, pred_acc.cnt);
                    pred_acc = '0;
                    want_q.push_back(b.typed ? b.want : r);
                end
            end
            n_taken++;
        end
    end

    always @(posedge i_clk) begin : out_mon
        hec_pkg::t_result w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results++;
            if (want_q.size() == 0) begin
                $error("unexpected result beat, ecc_code %h", o_ecc_code);
                n_errors++;
            end else begin
                w = want_q.pop_front();
                if (o_ecc_code !== w.ecc_code) begin
                    $error("ecc_code: expected %h, got %h", w.ecc_code, o_ecc_code);
                    n_errors++;
                end
                if (o_syndrome !== w.syndrome) begin
                    $error("syndrome: expected %h, got %h", w.syndrome, o_syndrome);
                    n_errors++;
                end
                if (o_status !== w.status) begin
                    $error("status: expected %0d, got %0d", w.status, o_status);
                    n_errors++;
                end
                if (o_error_byte !== w.error_byte) begin
                    $error("error_byte: expected %0d, got %0d", w.error_byte, o_error_byte);
                    n_errors++;
                end
                if (o_error_bit !== w.error_bit) begin
                    $error("error_bit: expected %0d, got %0d", w.error_bit, o_error_bit);
                    n_errors++;
                end
                if (o_fix_in_range !== w.fix_in_range) begin
                    $error("fix_in_range: expected %0d, got %0d", w.fix_in_range,
                           o_fix_in_range);
                    n_errors++;
                end
            end
        end
    end

    // receiver stall pattern, with one long hold-off to back up the input
    initial begin : out_stall
        int  mode;
        int  mode_left;
        int  hold_left;
        int  cyc;
        bit  held;
        logic rdy;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        cyc = 0;
        held = 0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0: rdy = 1'b1;
                    1: rdy = ($urandom_range(0, 3) != 0);
                    2: rdy = ($urandom_range(0, 9) < 3);
                    default: rdy = ((cyc % 7) < 4);
                endcase
            end
            if (!held && n_results >= 16) begin
                held = 1;
                hold_left = HOLD_OFF;
                rdy = 1'b0;
            end
            i_out_ready <= rdy;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin : main
        t_acc        dacc;
        t_beat       b;
        logic [23:0] ref_ecc;
        logic [23:0] e;
        int          n_rand;
        int          chunk_no;
        int          len;
        int          burst;
        int          gap;

        dir_tab = '{
            '{1'b0, 8'h00, 1'b1, STORED_LIT, 24'h000000, 1'b1,
              '{24'hffffff, 24'h000000, hec_pkg::ST_CLEAN, 9'd0, 3'd0, 1'b0}},
            '{1'b1, 8'h00, 1'b1, STORED_LIT, 24'hffffff, 1'b1,
              '{24'hffffff, 24'h000000, hec_pkg::ST_CLEAN, 9'd0, 3'd0, 1'b0}},
            '{1'b1, 8'h00, 1'b1, STORED_LIT, 24'hfffffe, 1'b1,
              '{24'hffffff, 24'h000001, hec_pkg::ST_ECC_ERR, 9'd0, 3'd0, 1'b0}},
            '{1'b1, 8'h00, 1'b1, STORED_LIT, 24'h7fffff, 1'b1,
              '{24'hffffff, 24'h800000, hec_pkg::ST_ECC_ERR, 9'd0, 3'd0, 1'b0}},
            '{1'b1, 8'h00, 1'b1, STORED_LIT, 24'h000000, 1'b1,
              '{24'hffffff, 24'hffffff, hec_pkg::ST_UNCORR, 9'd0, 3'd0, 1'b0}},
            '{1'b1, 8'h01, 1'b1, STORED_LIT, 24'hffffff, 1'b1,
              '{24'h555555, 24'haaaaaa, hec_pkg::ST_DATA_FIX, 9'd0, 3'd0, 1'b1}},
            '{1'b1, 8'h00, 1'b1, STORED_LIT, 24'h555595, 1'b1,
              '{24'hffffff, 24'haaaa6a, hec_pkg::ST_DATA_FIX, 9'd1, 3'd0, 1'b0}},
            '{1'b1, 8'h00, 1'b1, STORED_LIT, 24'haaaaaa, 1'b1,
              '{24'hffffff, 24'h555555, hec_pkg::ST_DATA_FIX, 9'h1ff, 3'd7, 1'b0}},
            '{1'b0, 8'hff, 1'b1, STORED_LIT, 24'hffffff, 1'b0, NO_WANT},
            // reference chunk in generate mode
            '{1'b1, 8'ha5, 1'b0, STORED_LIT, 24'h123456, 1'b0, NO_WANT},
            '{1'b1, 8'h3c, 1'b0, STORED_LIT, 24'h123456, 1'b0, NO_WANT},
            '{1'b1, 8'h80, 1'b0, STORED_LIT, 24'h123456, 1'b0, NO_WANT},
            '{1'b0, 8'h7e, 1'b1, STORED_LIT, 24'habcdef, 1'b0, NO_WANT},
            // same chunk with bit 3 of byte 2 flipped
            '{1'b1, 8'ha5, 1'b0, STORED_LIT, 24'h000000, 1'b0, NO_WANT},
            '{1'b1, 8'h3c, 1'b0, STORED_LIT, 24'h000000, 1'b0, NO_WANT},
            '{1'b1, 8'h88, 1'b0, STORED_LIT, 24'h000000, 1'b0, NO_WANT},
            '{1'b1, 8'h7e, 1'b1, STORED_REF, 24'h000000, 1'b0, NO_WANT},
            // clean data, stored ecc with one bad bit
            '{1'b0, 8'ha5, 1'b0, STORED_LIT, 24'hffffff, 1'b0, NO_WANT},
            '{1'b0, 8'h3c, 1'b0, STORED_LIT, 24'hffffff, 1'b0, NO_WANT},
            '{1'b0, 8'h80, 1'b0, STORED_LIT, 24'hffffff, 1'b0, NO_WANT},
            '{1'b1, 8'h7e, 1'b1, STORED_REF, 24'h000010, 1'b0, NO_WANT}
        };

        dacc = '0;
        ref_ecc = '0;
        foreach (dir_tab[r]) begin
            b.kind = dir_tab[r].kind;
            b.data = dir_tab[r].data;
            b.last = dir_tab[r].last;
            b.stored = dir_tab[r].stored;
            b.typed = dir_tab[r].typed;
            b.want = dir_tab[r].want;
            dacc = acc_fold(dacc, b.data);
            if (b.last) begin
                e = acc_ecc(dacc);
                if (dir_tab[r].src == STORED_REF)
                    b.stored = ref_ecc ^ dir_tab[r].stored;
                if (!b.kind)
                    ref_ecc = e;
                dacc = '0;
            end
            beat_q.push_back(b);
        end

        // mostly short chunks and one overlong chunk that wraps the byte index
        n_rand = 0;
        chunk_no = 0;
        while (n_rand < RAND_BEATS) begin
            if (chunk_no == 6)
                len = CHUNK_LEN + 18;
            else if ($urandom_range(0, 9) == 0)
                len = $urandom_range(25, 80);
            else
                len = $urandom_range(1, 16);
            add_chunk(len);
            n_rand += len;
            chunk_no++;
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        burst = $urandom_range(1, 20);
        foreach (beat_q[n]) begin
            if (burst == 0) begin
                gap = $urandom_range(1, 6);
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
                burst = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                    : $urandom_range(1, 20);
            end
            i_in_valid   <= 1'b1;
            i_kind       <= beat_q[n].kind;
            i_data_byte  <= beat_q[n].data;
            i_last       <= beat_q[n].last;
            i_stored_ecc <= beat_q[n].stored;
            do @(posedge i_clk); while (!o_in_ready);
            burst--;
        end
        i_in_valid <= 1'b0;

        while (want_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[nand_hamming_ecc_check_core.f]
hw/rtl/hec_pkg.sv
hw/rtl/hec_accum.sv
hw/rtl/hec_classify.sv
hw/rtl/nand_hamming_ecc_check_core.sv
hw/rtl/hec_check.sv
sim/nand_hamming_ecc_check_core_tb.sv
